### rtl/serpentine_scan_minmax_normalizer_assert.svh
// Assertion macros used by the checker file.
`ifndef SERPENTINE_SCAN_MINMAX_NORMALIZER_ASSERT_SVH
`define SERPENTINE_SCAN_MINMAX_NORMALIZER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SSMN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SSMN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/ssmn_pkg.sv
// Shared constants and types of the serpentine scan normaliser.
package ssmn_pkg;
	localparam int MaxWidth   = 64;
	localparam int MaxHeight  = 64;
	localparam int StoreDepth = MaxWidth * MaxHeight;
	localparam int AddrW      = $clog2(StoreDepth);
	localparam int ColW       = $clog2(MaxWidth);
	localparam int RowW       = $clog2(MaxHeight) + 1;
	localparam int DimW       = 7;
	localparam logic [0:0] KindSample  = 1'b0;
	localparam logic [0:0] KindRequest = 1'b1;
	localparam logic [0:0] RegWidth  = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	// request to the divider: offset and span, both non-negative
	typedef struct packed {
		logic        start;
		logic [16:0] off;
		logic [16:0] span;
	} div_req_t;

	// clamp a register value to 1..max
	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
	                                              input logic [DimW-1:0] mx);
		logic [DimW-1:0] r;
		r = v;
		if (v == '0) r = DimW'(1);
		else if (v > mx) r = mx;
		return r;
	endfunction
endpackage

### rtl/ssmn_ram.sv
// Generic single-port RAM with registered read.
module ssmn_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### rtl/ssmn_div.sv
// Restoring divider: floor(off*255/span) clamped to 8 bits, one bit a cycle.
module ssmn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ssmn_pkg::div_req_t req,
	output logic              done,
	output logic [7:0]        quot
);
	logic [24:0] num_q;
	logic [16:0] den_q;
	logic [17:0] rem_q;
	logic [24:0] qt_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;
	logic [24:0] prod;

	// off*255 = (off<<8) - off
	assign prod  = {req.off, 8'd0} - {8'd0, req.off};
	assign trial = {rem_q[16:0], num_q[24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd25;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= prod;
			den_q <= req.span;
			rem_q <= '0;
			qt_q  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[23:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				qt_q  <= {qt_q[23:0], 1'b1};
			end else begin
				rem_q <= trial;
				qt_q  <= {qt_q[23:0], 1'b0};
			end
		end
	end

	assign quot = (qt_q[24:8] != '0) ? 8'hFF : qt_q[7:0];
endmodule

### rtl/serpentine_scan_minmax_normalizer.sv
// Top level of the serpentine scan capture and min/max normaliser.
// Sample transfers (tuser kind 0) are taken one per cycle while the input is open;
// until the frame is complete, each writes both frame memories and updates the
// running extremes in the cycle it is accepted. A request transfer (kind 1) on a
// complete frame reads the pixel at the readout pointer from the memories, then runs
// the depth and thermal channels in turn through one shared bit-serial divider; the
// input stays closed until the pixel result is taken. A request before the frame is
// complete answers with status 1 in the next cycle. Register writes, and taking the
// result of the frame's last pixel, restart capture.
module serpentine_scan_minmax_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // depth_sample[7:0], thermal_sample[23:8]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // depth_pixel, thermal_pixel, pixel_index, pad
	output logic        m_tlast,
	output logic        m_tuser,   // status
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StRead = 3'd1;
	localparam logic [2:0] StDivD = 3'd2;
	localparam logic [2:0] StDivT = 3'd3;
	localparam logic [2:0] StOut  = 3'd4;

	logic [2:0] state_q;
	logic [6:0] width_q, height_q;
	logic [6:0] w_eff, h_eff;
	logic [ssmn_pkg::ColW-1:0] col_q;
	logic [ssmn_pkg::RowW-1:0] row_q;
	logic [7:0]  dmin_q, dmax_q;
	logic signed [15:0] tmin_q, tmax_q;
	logic [ssmn_pkg::AddrW-1:0] rptr_q;
	logic complete_q;
	logic [ssmn_pkg::AddrW-1:0] ram_addr, wr_addr;
	logic ram_we;
	logic [7:0]  d_rd;
	logic [15:0] t_rd;
	logic [7:0]  din;
	logic signed [15:0] tin;
	logic [6:0]  colsel;
	logic [12:0] addr_full;
	logic is_last;
	logic [7:0] dpix_q;
	logic [15:0] tval_q;
	ssmn_pkg::div_req_t dreq;
	logic ddone;
	logic [7:0] dquot;
	logic restart;
	logic accept;

	assign w_eff = ssmn_pkg::clamp_dim(width_q, 7'(ssmn_pkg::MaxWidth));
	assign h_eff = ssmn_pkg::clamp_dim(height_q, 7'(ssmn_pkg::MaxHeight));
	assign din = s_tdata[7:0];
	assign tin = s_tdata[23:8];
	assign s_tready = (state_q == StIdle) && !m_tvalid;
	assign accept = s_tvalid && s_tready;

	// serpentine column and store address
	assign colsel = row_q[0] ? 7'(col_q) : (w_eff - 7'd1 - 7'(col_q));
	assign addr_full = 13'(row_q) * 13'(w_eff) + 13'(colsel);
	assign wr_addr = addr_full[ssmn_pkg::AddrW-1:0];
	assign ram_we = accept && (s_tuser == ssmn_pkg::KindSample) && !complete_q;
	assign ram_addr = ram_we ? wr_addr : rptr_q;
	assign is_last = (13'(rptr_q) + 13'd1) >= (13'(w_eff) * 13'(h_eff));

	ssmn_ram #(.Width(8), .Depth(ssmn_pkg::StoreDepth)) u_dram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(din), .rdata(d_rd));
	ssmn_ram #(.Width(16), .Depth(ssmn_pkg::StoreDepth)) u_tram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(tin), .rdata(t_rd));

	// divider request for the current channel
	always_comb begin
		dreq = '0;
		if (state_q == StRead) begin
			dreq.start = 1'b1;
			if (dmax_q > dmin_q && d_rd > dmin_q) begin
				dreq.off  = 17'(d_rd - dmin_q);
				dreq.span = 17'(dmax_q - dmin_q);
			end else begin
				dreq.span = 17'd1;
			end
		end else if (state_q == StDivD && ddone) begin
			dreq.start = 1'b1;
			if (tmax_q > tmin_q && $signed(tval_q) > tmin_q) begin
				dreq.off  = 17'({tval_q[15], tval_q} - {tmin_q[15], tmin_q});
				dreq.span = 17'({tmax_q[15], tmax_q} - {tmin_q[15], tmin_q});
			end else begin
				dreq.span = 17'd1;
			end
		end
	end

	ssmn_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dquot));

	assign restart = (state_q == StOut) && m_tvalid && m_tready && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle; width_q <= 7'd64; height_q <= 7'd64;
			col_q <= '0; row_q <= '0; rptr_q <= '0; complete_q <= 1'b0;
			dmin_q <= 8'hFF; dmax_q <= 8'h00; tmin_q <= 16'sh7FFF; tmax_q <= 16'sh8000;
			m_tvalid <= 1'b0; m_tlast <= 1'b0; m_tuser <= 1'b0; m_tdata <= '0;
			dpix_q <= '0; tval_q <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (cfg_we || restart) begin
				if (cfg_we) begin
					unique case (cfg_index)
						ssmn_pkg::RegWidth:  width_q  <= cfg_data;
						ssmn_pkg::RegHeight: height_q <= cfg_data;
						default: ;
					endcase
				end
				col_q <= '0; row_q <= '0; rptr_q <= '0; complete_q <= 1'b0;
				dmin_q <= 8'hFF; dmax_q <= 8'h00;
				tmin_q <= 16'sh7FFF; tmax_q <= 16'sh8000;
			end
			if (restart) state_q <= StIdle;
			else if (state_q == StOut && m_tvalid && m_tready) begin
				state_q <= StIdle;
				rptr_q  <= rptr_q + 1'b1;
			end
			unique case (state_q)
				StIdle: begin
					if (accept && s_tuser == ssmn_pkg::KindSample && !complete_q) begin
						if (din > dmax_q) dmax_q <= din;
						if (din < dmin_q) dmin_q <= din;
						if (tin > tmax_q) tmax_q <= tin;
						if (tin < tmin_q) tmin_q <= tin;
						if (7'(col_q) + 7'd1 >= w_eff) begin
							col_q <= '0;
							if (7'(row_q) + 7'd1 >= h_eff) begin
								row_q <= '0; complete_q <= 1'b1; rptr_q <= '0;
							end else row_q <= row_q + 1'b1;
						end else col_q <= col_q + 1'b1;
					end else if (accept && s_tuser == ssmn_pkg::KindRequest) begin
						if (complete_q) state_q <= StRead;
						else begin
							m_tvalid <= 1'b1; m_tdata <= '0;
							m_tlast <= 1'b0; m_tuser <= 1'b1;
						end
					end
				end
				StRead: begin
					tval_q  <= t_rd;
					state_q <= StDivD;
				end
				StDivD: if (ddone) begin
					dpix_q  <= dquot;
					state_q <= StDivT;
				end
				StDivT: if (ddone) begin
					m_tvalid <= 1'b1;
					m_tuser <= 1'b0;
					m_tlast <= is_last;
					m_tdata <= {4'd0, 12'(rptr_q), dquot, dpix_q};
					state_q <= StOut;
				end
				StOut: ;
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule

### rtl/ssmn_checker.sv
// Port-level checker for the normaliser, bound to the top level.
`include "serpentine_scan_minmax_normalizer_assert.svh"
module ssmn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);
	`SSMN_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast, "error result carries data")
	`SSMN_ASSERT_IMP(a_busy_out, clk, arst_n, m_tvalid, !s_tready, "input taken while result waits")
	`SSMN_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`SSMN_ASSERT_IMP(a_pad, clk, arst_n, m_tvalid, m_tdata[31:28] == 4'd0, "pad bits set")
endmodule

bind serpentine_scan_minmax_normalizer ssmn_checker u_chk (.*);
